### rtl/core/lruf_pkg.sv
package lruf_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 8;
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W    = IDX_W;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int CFG_W     = 4;
  localparam int SLOT_W    = 3;
  localparam int FAULT_W   = 16;
  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_status_t;

endpackage

### rtl/core/lruf_datapath.sv
module lruf_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [lruf_pkg::CFG_W-1:0]   cfg_write_data,
  input  logic                         load_page,
  input  logic [lruf_pkg::PAGE_BITS-1:0] page,
  input  lruf_pkg::dp_cmd_t            cmd,
  output lruf_pkg::dp_status_t         status,
  output logic                         hit,
  output logic [lruf_pkg::SLOT_W-1:0]  frame_slot,
  output logic                         victim_valid,
  output logic [lruf_pkg::PAGE_BITS-1:0] victim_page,
  output logic [lruf_pkg::FAULT_W-1:0] fault_total
);
  import lruf_pkg::*;

  logic [CFG_W-1:0]     frames_in_use;
  logic [PAGE_BITS-1:0] frame_page [FRAMES];
  logic [FRAMES-1:0]    frame_valid;
  logic [RANK_W-1:0]    recency_rank [FRAMES];
  logic [FAULT_W-1:0]   fault_count;

  logic [PAGE_BITS-1:0] page_q;
  logic [IDX_W-1:0]     idx;
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_slot;
  logic [RANK_W-1:0]    hit_rank;
  logic                 empty_found;
  logic [IDX_W-1:0]     empty_slot;
  logic [IDX_W-1:0]     old_slot;
  logic [RANK_W-1:0]    old_rank;
  logic [PAGE_BITS-1:0] old_page;

  logic [31:0]          raw32;
  logic [CNT_W-1:0]     n_eff;
  logic                 cur_valid;
  logic [PAGE_BITS-1:0] cur_page;
  logic [RANK_W-1:0]    cur_rank;
  logic [IDX_W-1:0]     slot;
  logic                 was_valid;
  logic [RANK_W-1:0]    ref_rank;
  logic                 evict;
  logic [FAULT_W-1:0]   fault_next;
  logic [31:0]          slot32;

  assign raw32 = 32'(frames_in_use);
  assign n_eff = (raw32 == 32'd0) ? CNT_W'(1) :
                 (raw32 > 32'(FRAMES)) ? CNT_W'(FRAMES) : CNT_W'(raw32);
  assign status.scan_last = (32'(idx) + 32'd1) == 32'(n_eff);

  assign cur_valid = frame_valid[idx];
  assign cur_page  = frame_page[idx];
  assign cur_rank  = recency_rank[idx];

  assign slot      = hit_found ? hit_slot : (empty_found ? empty_slot : old_slot);
  assign was_valid = hit_found || !empty_found;
  assign ref_rank  = hit_found ? hit_rank : old_rank;
  assign evict     = !hit_found && !empty_found;
  assign fault_next = (!hit_found && fault_count != FAULT_MAX) ?
                      fault_count + FAULT_W'(1) : fault_count;
  assign slot32    = 32'(slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_W'(FRAMES);
    end else if (cfg_write_en) begin
      frames_in_use <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (load_page) begin
      page_q <= page;
    end
  end

  // scan one frame per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end else if (cmd.start) begin
      idx         <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end else if (cmd.scan_step) begin
      idx <= idx + IDX_W'(1);
      if (!hit_found && cur_valid && cur_page == page_q) begin
        hit_found <= 1'b1;
      end
      if (!empty_found && !cur_valid) begin
        empty_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      if (!hit_found && cur_valid && cur_page == page_q) begin
        hit_slot <= idx;
        hit_rank <= cur_rank;
      end
      if (!empty_found && !cur_valid) begin
        empty_slot <= idx;
      end
      if (idx == '0 || cur_rank > old_rank) begin
        old_slot <= idx;
        old_rank <= cur_rank;
        old_page <= cur_page;
      end
    end
  end

  // update recency, contents and fault count
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      fault_count <= '0;
      for (int j = 0; j < FRAMES; j++) begin
        recency_rank[j] <= '0;
      end
    end else if (cmd.commit) begin
      frame_valid[slot] <= 1'b1;
      fault_count       <= fault_next;
      for (int j = 0; j < FRAMES; j++) begin
        if (IDX_W'(j) == slot) begin
          recency_rank[j] <= '0;
        end else if (frame_valid[j] && (!was_valid || recency_rank[j] < ref_rank)) begin
          recency_rank[j] <= recency_rank[j] + RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_found) begin
      frame_page[slot] <= page_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit          <= hit_found;
      frame_slot   <= slot32[SLOT_W-1:0];
      victim_valid <= evict;
      victim_page  <= evict ? old_page : '0;
      fault_total  <= fault_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_fault_hold_on_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && hit_found |=> fault_count == $past(fault_count))
    else $error("fault count changed on a hit");

  a_slot_valid_after_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> frame_valid[$past(slot)])
    else $error("frame not valid after commit");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> 32'(idx) < 32'(n_eff))
    else $error("scan index beyond frames in use");
`endif

endmodule

### rtl/core/lruf_controller.sv
module lruf_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 load_page,
  output lruf_pkg::dp_cmd_t    cmd,
  input  lruf_pkg::dp_status_t status
);
  import lruf_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    load_page     = 1'b0;
    cmd.start     = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.commit    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        load_page = in_valid;
        cmd.start = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> out_free)
    else $error("result overwritten before transaction");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_SCAN)
    else $error("accepted transaction did not start a scan");

  a_last_goes_commit: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && status.scan_last |=> state == ST_COMMIT)
    else $error("scan did not end in commit");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not presented after commit");
`endif

endmodule

### rtl/core/lru_frame_replacement.sv
// LRU frame replacement: each page reference is checked against the frames in
// use (frames_in_use, clamped to 1..8), hits refresh recency, misses fill the
// lowest empty frame or evict the least recently used one and bump a
// saturating fault count. Each reference is accepted, then checked against
// the frame table in a serial scan of the frames in use, and finally committed,
// which updates the table and loads the result register. A
// new reference is taken while the previous result still waits on out_ready;
// its commit waits until that result has gone.
module lru_frame_replacement (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [lruf_pkg::CFG_W-1:0]      cfg_write_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lruf_pkg::PAGE_BITS-1:0]  page,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [lruf_pkg::SLOT_W-1:0]     frame_slot,
  output logic                            victim_valid,
  output logic [lruf_pkg::PAGE_BITS-1:0]  victim_page,
  output logic [lruf_pkg::FAULT_W-1:0]    fault_total
);
  import lruf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       load_page;

  lruf_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .load_page (load_page),
    .cmd       (cmd),
    .status    (status)
  );

  lruf_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .load_page      (load_page),
    .page           (page),
    .cmd            (cmd),
    .status         (status),
    .hit            (hit),
    .frame_slot     (frame_slot),
    .victim_valid   (victim_valid),
    .victim_page    (victim_page),
    .fault_total    (fault_total)
  );

endmodule

### dv/tb_lru_frame_replacement.sv
`timescale 1ns / 1ps

module tb_lru_frame_replacement;
  import lruf_pkg::*;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    frame_slot;
    logic                 victim_valid;
    logic [PAGE_BITS-1:0] victim_page;
    logic [FAULT_W-1:0]   fault_total;
  } lru_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_W-1:0]     cfg_write_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PAGE_BITS-1:0] page = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 hit;
  logic [SLOT_W-1:0]    frame_slot;
  logic                 victim_valid;
  logic [PAGE_BITS-1:0] victim_page;
  logic [FAULT_W-1:0]   fault_total;

  lru_frame_replacement dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .page           (page),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .frame_slot     (frame_slot),
    .victim_valid   (victim_valid),
    .victim_page    (victim_page),
    .fault_total    (fault_total)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // shadow of the frame table
  logic [PAGE_BITS-1:0] resident_page [FRAMES];
  bit                   resident_valid [FRAMES];
  bit [7:0]             age_rank [FRAMES];
  bit [FAULT_W-1:0]     fault_sum;
  bit [CFG_W-1:0]       frames_cfg;

  logic [PAGE_BITS-1:0] pending_pages [$];
  lru_result_t          expected_results [$];

  int errors = 0;
  int results_seen = 0;
  int hits_predicted = 0;
  int evictions_predicted = 0;
  int gap_left = 0;
  int burst_left = 0;
  int max_gap = 0;
  int hold_left = 0;
  bit long_hold_req = 1'b0;
  bit [15:0] ready_pattern = '1;
  bit [3:0] ready_idx = '0;

  function automatic void promote_frame(input int idx, input bit was_valid);
    bit [7:0] r;
    r = was_valid ? age_rank[idx] : 8'hFF;
    for (int j = 0; j < FRAMES; j++) begin
      if (j != idx && resident_valid[j] && age_rank[j] < r) age_rank[j]++;
    end
    age_rank[idx] = '0;
  endfunction

  function automatic lru_result_t predict_reference(input logic [PAGE_BITS-1:0] pg);
    lru_result_t res;
    int n;
    int slot;
    res = '0;
    n = (frames_cfg < 1) ? 1 : (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
    slot = -1;
    for (int j = 0; j < n; j++) begin
      if (slot < 0 && resident_valid[j] && resident_page[j] == pg) slot = j;
    end
    if (slot >= 0) begin
      res.hit = 1'b1;
      promote_frame(slot, 1'b1);
    end else begin
      for (int j = 0; j < n; j++) begin
        if (slot < 0 && !resident_valid[j]) slot = j;
      end
      if (slot >= 0) begin
        promote_frame(slot, 1'b0);
        resident_valid[slot] = 1'b1;
        resident_page[slot] = pg;
      end else begin
        slot = 0;
        for (int j = 1; j < n; j++) begin
          if (age_rank[j] > age_rank[slot]) slot = j;
        end
        res.victim_valid = 1'b1;
        res.victim_page = resident_page[slot];
        promote_frame(slot, 1'b1);
        resident_page[slot] = pg;
      end
      if (fault_sum != FAULT_MAX) fault_sum++;
    end
    res.frame_slot = slot[SLOT_W-1:0];
    res.fault_total = fault_sum;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // sender: bursts with random gaps
  always @(posedge clk) begin
    lru_result_t want;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        want = predict_reference(page);
        if (want.hit) hits_predicted++;
        if (want.victim_valid) evictions_predicted++;
        expected_results.push_back(want);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_pages.size() > 0) begin
          page <= pending_pages.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ready_pattern[ready_idx];
      ready_idx += 4'($urandom_range(1, 2));
    end
  end

  always @(posedge clk) begin
    lru_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, slot %0d", frame_slot));
      end else begin
        want = expected_results.pop_front();
        if (hit !== want.hit)
          report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
        if (frame_slot !== want.frame_slot)
          report_mismatch($sformatf("frame_slot %0d, want %0d", frame_slot, want.frame_slot));
        if (victim_valid !== want.victim_valid)
          report_mismatch($sformatf("victim_valid %b, want %b", victim_valid,
                                    want.victim_valid));
        if (victim_page !== want.victim_page)
          report_mismatch($sformatf("victim_page %h, want %h", victim_page, want.victim_page));
        if (fault_total !== want.fault_total)
          report_mismatch($sformatf("fault_total %0d, want %0d", fault_total,
                                    want.fault_total));
      end
    end
  end

  task automatic wait_for_idle();
    do @(negedge clk);
    while (pending_pages.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    wait_for_idle();
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    frames_cfg = v;
  endtask

  task automatic set_pacing(input int mode);
    case (mode)
      0: begin
        ready_pattern = '1;
        max_gap = 0;
      end
      1: begin
        ready_pattern = 16'($urandom) | 16'h8421;
        max_gap = 3;
      end
      default: begin
        ready_pattern = 16'($urandom & $urandom) | 16'h0001;
        max_gap = 12;
      end
    endcase
  endtask

  function automatic logic [PAGE_BITS-1:0] pick_page(input int n, input int i,
                                                     input logic [PAGE_BITS-1:0] base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return PAGE_BITS'($urandom_range(0, 255));
    if (r < 30) return base + PAGE_BITS'(i % (n + 1));
    return base + PAGE_BITS'($urandom_range(0, n + 2));
  endfunction

  initial begin
    logic [CFG_W-1:0] cfg_plan [13] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd9, 4'd2,
                                        4'd7, 4'd4, 4'd6, 4'd12, 4'd8};
    logic [PAGE_BITS-1:0] base;
    int n;
    for (int j = 0; j < FRAMES; j++) begin
      resident_page[j] = '0;
      resident_valid[j] = 1'b0;
      age_rank[j] = '0;
    end
    fault_sum = '0;
    frames_cfg = 4'd8;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // fill all frames, hit, then evict in recency order
    pending_pages = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
                      8'h80, 8'hAA, 8'h55};
    // shrink while resident: a page can end up in two frames
    write_frames(4'd2);
    pending_pages = '{8'h80, 8'h03};
    write_frames(4'd8);
    pending_pages.push_back(8'h03);
    // out-of-range frame counts are clamped
    write_frames(4'd0);
    pending_pages = '{8'h07, 8'h07, 8'hFF};
    write_frames(4'd15);
    pending_pages = '{8'h5A, 8'h00};
    write_frames(4'd1);
    pending_pages = '{8'hFF, 8'h01};

    foreach (cfg_plan[k]) begin
      write_frames(cfg_plan[k]);
      set_pacing(k % 3);
      n = (cfg_plan[k] < 1) ? 1 : (cfg_plan[k] > FRAMES) ? FRAMES : int'(cfg_plan[k]);
      base = PAGE_BITS'($urandom_range(0, 255));
      for (int i = 0; i < 125; i++) begin
        if (i % 40 == 39) base += PAGE_BITS'($urandom_range(0, 3));
        pending_pages.push_back(pick_page(n, i, base));
      end
      if (k == 1) begin
        repeat (40) @(negedge clk);
        long_hold_req = 1'b1;
      end
    end

    write_frames(4'd8);
    set_pacing(2);
    base = PAGE_BITS'($urandom_range(0, 255));
    for (int i = 0; i < 60; i++) pending_pages.push_back(pick_page(8, i, base));
    wait_for_idle();
    repeat (20) @(posedge clk);

    $display("checked %0d references: %0d hits, %0d evictions, frame counts 0 to 15",
             results_seen, hits_predicted, evictions_predicted);
    $display("fault count ended at %0d, long output stall and idle pauses exercised",
             fault_sum);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
